/* rtl/core/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants and types for the vector softmax block.
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

    // Vector and field geometry.
    localparam int VECTOR_DEPTH = 64;
    localparam int ADDR_W       = 6;
    localparam int CNT_W        = 7;
    localparam int VALUE_W      = 24;
    localparam int PROB_W       = 16;
    localparam int E_W          = 17;
    localparam int SUM_W        = 23;

    // Shared divider geometry.
    localparam int DIV_N_W      = 36;
    localparam int DIV_D_W      = 23;
    localparam int DIV_BITS     = 4;
    localparam int DIV_STEPS    = DIV_N_W / DIV_BITS;

    // Exponential constants.
    localparam int          TAYLOR_TERMS    = 13;
    localparam logic [30:0] EXP_NEG_ONE_Q32 = 31'd1580030169;
    localparam logic [16:0] EXP_K_LIMIT     = 17'd65536;

    localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

/* rtl/core/smx_ram.sv */
// ----------------------------------------------------------------------------
// smx_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/smx_div.sv */
// ----------------------------------------------------------------------------
// smx_div
// Shared restoring divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_div
    import smx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [DIV_N_W-1:0] r_quo, n_quo;
    logic [DIV_D_W-1:0] r_rem, n_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [3:0]         r_cnt;
    logic               r_busy;
    logic               r_done;

    // Four dependent shift and subtract steps.
    always_comb begin
        logic [DIV_D_W:0] rem;
        rem   = {1'b0, r_rem};
        n_quo = r_quo;
        for (int b = 0; b < DIV_BITS; b++) begin
            rem   = {rem[DIV_D_W-1:0], n_quo[DIV_N_W-1]};
            n_quo = {n_quo[DIV_N_W-2:0], 1'b0};
            if (rem >= {1'b0, r_den}) begin
                rem      = rem - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
        end
        n_rem = rem[DIV_D_W-1:0];
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

/* rtl/core/smx_exp.sv */
// ----------------------------------------------------------------------------
// smx_exp
// Iterative exp(-k/4096) in Q1.16: a Taylor series for the fraction, then
// one multiplication by exp(-1) per whole unit.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_exp
    import smx_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [24:0]   i_k,
    output t_div_req           o_div_req,
    input  wire t_div_rsp      i_div_rsp,
    output logic               o_done,
    output logic [E_W-1:0]     o_e
);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_TMUL = 3'd1;
    localparam logic [2:0] E_TGO  = 3'd2;
    localparam logic [2:0] E_TWT  = 3'd3;
    localparam logic [2:0] E_MLO  = 3'd4;
    localparam logic [2:0] E_MHI  = 3'd5;
    localparam logic [2:0] E_MSUM = 3'd6;
    localparam logic [2:0] E_OUT  = 3'd7;

    logic [2:0]         r_state;
    logic [4:0]         r_n;
    logic [11:0]        r_f;
    logic [32:0]        r_term;
    logic [33:0]        r_s;
    logic [3:0]         r_j;
    logic [DIV_N_W-1:0] r_num;
    logic [46:0]        r_plo;
    logic [47:0]        r_phi;
    logic [E_W-1:0]     r_e;
    logic               r_done;
    logic [44:0]        tprod;
    logic [64:0]        msum;

    assign tprod = r_term * r_f;
    assign msum  = {1'b0, r_phi, 16'd0} + {18'd0, r_plo} + 65'h0_8000_0000;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        if (i_k > {8'd0, EXP_K_LIMIT}) begin
                            r_e    <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_n     <= i_k[16:12];
                            r_f     <= i_k[11:0];
                            r_term  <= 33'h1_0000_0000;
                            r_s     <= 34'h1_0000_0000;
                            r_j     <= 4'd1;
                            r_state <= E_TMUL;
                        end
                    end
                end
                E_TMUL: begin
                    r_num   <= DIV_N_W'(tprod >> 12);
                    r_state <= E_TGO;
                end
                E_TGO: begin
                    r_state <= E_TWT;
                end
                E_TWT: begin
                    if (i_div_rsp.done) begin
                        r_term <= i_div_rsp.quo[32:0];
                        if (r_j[0]) begin
                            r_s <= r_s - {1'b0, i_div_rsp.quo[32:0]};
                        end else begin
                            r_s <= r_s + {1'b0, i_div_rsp.quo[32:0]};
                        end
                        r_j <= r_j + 4'd1;
                        if (r_j == 4'(TAYLOR_TERMS)) begin
                            r_state <= (r_n == 5'd0) ? E_OUT : E_MLO;
                        end else begin
                            r_state <= E_TMUL;
                        end
                    end
                end
                E_MLO: begin
                    r_plo   <= r_s[15:0] * EXP_NEG_ONE_Q32;
                    r_state <= E_MHI;
                end
                E_MHI: begin
                    r_phi   <= r_s[32:16] * EXP_NEG_ONE_Q32;
                    r_state <= E_MSUM;
                end
                E_MSUM: begin
                    r_s     <= {1'b0, msum[64:32]};
                    r_n     <= r_n - 5'd1;
                    r_state <= (r_n == 5'd1) ? E_OUT : E_MLO;
                end
                E_OUT: begin
                    r_e     <= E_W'((r_s + 34'h8000) >> 16);
                    r_done  <= 1'b1;
                    r_state <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    // Each term is divided by its index on the shared divider.
    assign o_div_req.start = (r_state == E_TGO);
    assign o_div_req.num   = r_num;
    assign o_div_req.den   = DIV_D_W'(r_j);

    assign o_done = r_done;
    assign o_e    = r_e;

endmodule

`default_nettype wire

/* rtl/core/softmax_vector.sv */
// ----------------------------------------------------------------------------
// softmax_vector
// Numerically stable softmax over a vector of up to 64 Q12.12 elements.
// ----------------------------------------------------------------------------
// Channel | Dir | Fields
// s       | in  | tdata: value[23:0]; tlast: last
// m       | out | tdata: probability[15:0], index[21:16]; tlast: final_out;
//         |     | tuser: overflow
//
// Loading accepts one element per cycle. After the last element each element
// goes through the exponential pass (13 series terms, each divided on the
// shared four-bit-per-cycle divider, then one multiply by exp(-1) for each
// of up to 16 whole units), or is flushed to zero when its distance below the
// maximum exceeds 16, and then through the normalizing pass (one division by the sum).
// Reset is synchronous and active low; there is no clearing pass.
// No input is accepted during the two passes; a stalled output holds the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module softmax_vector
    import smx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // value[23:0]
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [23:0] o_m_tdata,   // probability[15:0], index[21:16], zero
    output logic             o_m_tlast,
    output logic             o_m_tuser    // overflow
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_XRD  = 3'd1;
    localparam logic [2:0] S_XST  = 3'd2;
    localparam logic [2:0] S_XWT  = 3'd3;
    localparam logic [2:0] S_NRD  = 3'd4;
    localparam logic [2:0] S_NST  = 3'd5;
    localparam logic [2:0] S_NWT  = 3'd6;
    localparam logic [2:0] S_NPUT = 3'd7;

    logic [2:0]                r_state;
    logic signed [VALUE_W-1:0] r_max;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_idx;
    logic [SUM_W-1:0]          r_sum;
    logic                      r_dropped;
    logic [PROB_W-1:0]         r_prob;
    logic                      r_ovalid;
    logic [PROB_W-1:0]         r_oprob;
    logic [ADDR_W-1:0]         r_oidx;
    logic                      r_olast;
    logic                      r_oflow;

    logic                      accept;
    logic signed [VALUE_W-1:0] in_value;
    logic                      store_we;
    logic [VALUE_W-1:0]        store_rdata;
    logic                      e_we;
    logic [E_W-1:0]            e_rdata;
    logic [24:0]               diff;
    logic                      exp_start;
    logic                      exp_done;
    logic [E_W-1:0]            exp_e;
    t_div_req                  exp_req;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    logic                      out_free;

    assign in_value   = signed'(i_s_tdata);
    assign o_s_tready = (r_state == S_LOAD);
    assign accept     = i_s_tvalid && o_s_tready;
    assign store_we   = accept && (r_count < CNT_W'(VECTOR_DEPTH));
    assign out_free   = !r_ovalid || i_m_tready;

    // Element store and exponential store.
    smx_ram #(.WIDTH(VALUE_W), .DEPTH(VECTOR_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_s_tdata),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (store_rdata)
    );

    smx_ram #(.WIDTH(E_W), .DEPTH(VECTOR_DEPTH)) u_estore (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_idx[ADDR_W-1:0]),
        .i_wdata (exp_e),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (e_rdata)
    );

    // Distance below the maximum, never negative.
    assign diff      = {r_max[VALUE_W-1], r_max} - {store_rdata[VALUE_W-1], store_rdata};
    assign exp_start = (r_state == S_XST);
    assign e_we      = (r_state == S_XWT) && exp_done;

    smx_exp u_exp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (exp_start),
        .i_k       (diff),
        .o_div_req (exp_req),
        .i_div_rsp (div_rsp),
        .o_done    (exp_done),
        .o_e       (exp_e)
    );

    // The divider serves the series terms and then the normalization.
    always_comb begin
        if (r_state == S_NST) begin
            div_req.start = 1'b1;
            div_req.num   = {3'd0, e_rdata, 16'd0};
            div_req.den   = r_sum;
        end else begin
            div_req = exp_req;
        end
    end

    smx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_max     <= MOST_NEG;
            r_count   <= '0;
            r_idx     <= '0;
            r_sum     <= '0;
            r_dropped <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (store_we) begin
                            r_count <= r_count + CNT_W'(1);
                            if (in_value > r_max) begin
                                r_max <= in_value;
                            end
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_s_tlast) begin
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_state <= S_XRD;
                        end
                    end
                end
                S_XRD: r_state <= S_XST;
                S_XST: r_state <= S_XWT;
                S_XWT: begin
                    if (exp_done) begin
                        r_sum <= r_sum + SUM_W'(exp_e);
                        if (r_idx + CNT_W'(1) == r_count) begin
                            r_idx   <= '0;
                            r_state <= S_NRD;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_XRD;
                        end
                    end
                end
                S_NRD: r_state <= S_NST;
                S_NST: r_state <= S_NWT;
                S_NWT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quo > DIV_N_W'({PROB_W{1'b1}})) begin
                            r_prob <= {PROB_W{1'b1}};
                        end else begin
                            r_prob <= div_rsp.quo[PROB_W-1:0];
                        end
                        r_state <= S_NPUT;
                    end
                end
                S_NPUT: begin
                    if (out_free) begin
                        if (r_idx + CNT_W'(1) == r_count) begin
                            r_max     <= MOST_NEG;
                            r_count   <= '0;
                            r_idx     <= '0;
                            r_sum     <= '0;
                            r_dropped <= 1'b0;
                            r_state   <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_NRD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_NPUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_NPUT && out_free) begin
            r_oprob <= r_prob;
            r_oidx  <= r_idx[ADDR_W-1:0];
            r_olast <= (r_idx + CNT_W'(1) == r_count);
            r_oflow <= r_dropped;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_oidx, r_oprob};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oflow;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(VECTOR_DEPTH))
        else $error("element count beyond depth");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_idx < r_count))
        else $error("pass index beyond stored elements");

    a_sum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NST) |-> (r_sum != '0))
        else $error("exponential sum is zero at normalization");

    a_no_load_mid_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XWT && !exp_done) |=> (r_state == S_XWT) && $stable(r_idx))
        else $error("exponential pass moved on without a result");
`endif

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vector softmax block: random and directed
// vectors are streamed in, expected probabilities are predicted per vector
// and compared field by field with every result on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import smx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One predicted softmax output.
    typedef struct packed {
        logic [15:0] prob;
        logic [5:0]  idx;
        logic        final_out;
        logic        overflow;
    } t_prob_rec;

    // Softmax predictor with its own copy of the vector state.
    class softmax_scoreboard;
        logic signed [23:0] elems[64];
        logic signed [23:0] vec_max;
        int unsigned        elem_cnt;
        bit                 dropped;
        t_prob_rec          pending[$];
        int                 errors;

        function new();
            errors = 0;
            clear_vector();
        endfunction

        function void clear_vector();
            vec_max  = MOST_NEG;
            elem_cnt = 0;
            dropped  = 0;
        endfunction

        // exp(-k / 4096) in Q1.16, flushed to zero below -16.
        function logic [16:0] exp_neg(logic [31:0] k);
            logic [31:0] n;
            logic [31:0] f;
            logic [63:0] term;
            logic [63:0] s;
            if (k > 32'd65536) return 17'd0;
            n    = k >> 12;
            f    = k & 32'd4095;
            term = 64'd1 << 32;
            s    = term;
            for (int j = 1; j <= 13; j++) begin
                term = (term * f) / (64'd4096 * j);
                if (j % 2 == 1) s = s - term;
                else s = s + term;
            end
            for (int j = 0; j < n; j++) begin
                s = (s * 64'd1580030169 + (64'd1 << 31)) >> 32;
            end
            return 17'((s + 64'h8000) >> 16);
        endfunction

        // Note one accepted request; a last mark closes the vector.
        function void note_request(logic signed [23:0] value, logic last);
            logic [16:0] e[64];
            logic [22:0] sum;
            logic [63:0] p;
            t_prob_rec   rec;
            if (elem_cnt < VECTOR_DEPTH) begin
                elems[elem_cnt] = value;
                if (value > vec_max) vec_max = value;
                elem_cnt++;
            end else begin
                dropped = 1;
            end
            if (!last) return;
            sum = 0;
            for (int i = 0; i < elem_cnt; i++) begin
                e[i] = exp_neg(32'(vec_max - elems[i]));
                sum  = sum + e[i];
            end
            for (int i = 0; i < elem_cnt; i++) begin
                p = (sum != 0) ? (64'(e[i]) << 16) / sum : 64'd0;
                if (p > 64'd65535) p = 64'd65535;
                rec.prob      = p[15:0];
                rec.idx       = 6'(i);
                rec.final_out = (i + 1 == elem_cnt);
                rec.overflow  = dropped;
                pending.push_back(rec);
            end
            clear_vector();
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(t_prob_rec got);
            t_prob_rec want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.prob !== want.prob) begin
                $display("%0t: probability expected %0d actual %0d", $time,
                         want.prob, got.prob);
                errors++;
            end
            if (got.idx !== want.idx) begin
                $display("%0t: index expected %0d actual %0d", $time, want.idx, got.idx);
                errors++;
            end
            if (got.final_out !== want.final_out) begin
                $display("%0t: last expected %0b actual %0b", $time,
                         want.final_out, got.final_out);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %0b actual %0b", $time,
                         want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // value[23:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // probability[15:0], index[21:16], zero
    logic        m_tlast;
    logic        m_tuser;   // overflow

    softmax_scoreboard sb;
    bit                quiet_phase;
    bit                long_hold;
    int                ready_gap;
    longint            cycle_cnt = 0;

    softmax_vector i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // Send one element; an idle burst may precede it.
    task automatic send_elem(logic [23:0] value, logic last);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(value, last);
    endtask

    // Random element near a base so that exponents stay interesting.
    function automatic logic [23:0] near(logic signed [23:0] base);
        case ($urandom_range(0, 4))
            0: return 24'($urandom);
            1: return base;
            default: return base - 24'($urandom_range(0, 20 * 4096));
        endcase
    endfunction

    task automatic send_vector(int len, logic [1:0] mode);
        logic signed [23:0] base;
        base = 24'($urandom);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: send_elem(near(base), i == len - 1);
                1: send_elem(24'($urandom), i == len - 1);
                default: send_elem(base, i == len - 1);
            endcase
        end
    endtask

    // Output side: random idle bursts, one long hold while input keeps coming.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready  <= 0;
            ready_gap <= 0;
        end else if (long_hold) begin
            m_tready <= 0;
        end else if (!quiet_phase && ready_gap > 0) begin
            m_tready  <= 0;
            ready_gap <= ready_gap - 1;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            m_tready  <= 0;
            ready_gap <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1;
        end
        if (rst_n && m_tvalid && m_tready)
            sb.check_result({m_tdata[15:0], m_tdata[21:16], m_tlast, m_tuser});
    end

    // Run guard.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 64'd3000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int sent;
        int len;
        sb          = new();
        quiet_phase = 0;
        long_hold   = 0;
        rst_n       <= 0;
        s_tvalid    <= 0;
        s_tdata     <= 0;
        s_tlast     <= 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, single element, saturation, flush.
        send_elem(24'h7FFFFF, 1);
        send_elem(24'h800000, 0);
        send_elem(24'h7FFFFF, 1);
        send_elem(24'h000000, 0);
        send_elem(24'h000000, 1);
        send_elem(24'h001000, 0);
        send_elem(24'hFF0000, 0);
        send_elem(24'hFEFFFF, 0);
        send_elem(24'h000800, 1);
        send_elem(24'h555555, 0);
        send_elem(24'hAAAAAA, 1);

        // Long output hold while a 20-element vector streams in.
        long_hold = 1;
        fork
            send_vector(20, 0);
            begin
                repeat (3000) @(posedge clk);
                long_hold = 0;
            end
        join
        sent = 31;

        // Overfull store: drops flagged, last on a dropped element.
        for (int i = 0; i < 66; i++) send_elem(24'($urandom), i == 65);
        sent += 66;

        // Random vectors, mostly short, a few full depth.
        while (sent < 360) begin
            if (sent > 300) quiet_phase = 1;
            len = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 8);
            send_vector(len, 2'($urandom_range(0, 3)));
            sent += len;
        end
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
